// ===== src/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared widths, codes, register indexes and state type of the fixed-block
// pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    // Field widths of the request and response channels.
    localparam int OP_W     = 2;
    localparam int HANDLE_W = 12;
    localparam int OFFSET_W = 20;
    localparam int COUNT_W  = 13;
    localparam int PCOUNT_W = 5;

    // Configuration register widths and bus geometry.
    localparam int REQ_W    = 16;
    localparam int ALIGN_W  = 13;
    localparam int PAGE_W   = 17;
    localparam int STRIDE_W = 17;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;
    localparam int REG_IDX_W = 2;

    // Register reset values.
    localparam logic [REQ_W-1:0]   REQ_RESET   = 16'd16;
    localparam logic [ALIGN_W-1:0] ALIGN_RESET = 13'd8;
    localparam logic [PAGE_W-1:0]  PAGE_RESET  = 17'd4096;

    // Saturation limit of the free-block count.
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

    // Iterative divider geometry.
    localparam int DIV_W     = 17;
    localparam int DIV_CNT_W = 5;

    // Width of the handle times reciprocal product used to split a handle.
    localparam int FPROD_W = 2 * HANDLE_W;

    // Register indexes on the configuration port.
    localparam logic [REG_IDX_W-1:0] REG_REQ   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ALIGN = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PAGE  = 2'd2;

    // Response status codes.
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_OOM = 1'b1;

    // Request operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_RELEASE = 2'd2
    } t_op;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_LINK,
        ST_FREE,
        ST_DERIVE,
        ST_DIV
    } t_state;

endpackage

// ===== src/fbpa_if.sv =====
// ----------------------------------------------------------------------------
// fbpa_if
// Valid/ready channels of the allocator: the request channel and the
// response channel, each with a source and a sink view.
// ----------------------------------------------------------------------------
interface fbpa_in_if import fbpa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [HANDLE_W-1:0] handle;

    modport source (output valid, output op, output handle, input ready);
    modport sink   (input valid, input op, input handle, output ready);
endinterface

interface fbpa_out_if import fbpa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                status;
    logic [HANDLE_W-1:0] block_handle;
    logic [OFFSET_W-1:0] byte_offset;
    logic [COUNT_W-1:0]  free_count;
    logic [PCOUNT_W-1:0] page_count;

    modport source (output valid, output status, output block_handle,
                    output byte_offset, output free_count, output page_count,
                    input ready);
    modport sink   (input valid, input status, input block_handle,
                    input byte_offset, input free_count, input page_count,
                    output ready);
endinterface

// ===== src/fixed_block_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Pool of fixed-size blocks on a LIFO free list held in a link memory.
// ----------------------------------------------------------------------------
// Usage.
// Requests arrive on i_req (op, handle) and each one gives exactly one
// response on o_rsp, in order. A transfer happens when valid and ready are
// both high at a rising edge of i_clk.
// Allocate pops the head of the free list with one read of the link memory.
// When no block is free it first opens a new page and writes that page's
// links one per cycle. Free pushes a handle: the handle is split into page
// slot and index, then the link is written. Release-all and the unused op
// code are answered from the idle state.
// The response sits in an output register; while the receiver stalls, one
// further request is taken and its result is held until the register frees.
// At reset, and after every configuration write, the block stride is
// worked out and blocks per page are divided out bit-serially; i_req.ready
// stays low meanwhile. A configuration write also empties every page.
// The link memory is not cleared.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator import fbpa_pkg::*; #(
    parameter int MAX_PAGES           = 16,
    parameter int MAX_BLOCKS_PER_PAGE = 256,
    parameter int BLOCK_HEADER_BYTES  = 8,
    parameter int PAGE_HEADER_BYTES   = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    fbpa_in_if.sink           i_req,
    fbpa_out_if.source        o_rsp
);

    localparam int PW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int IW  = (MAX_BLOCKS_PER_PAGE > 1) ? $clog2(MAX_BLOCKS_PER_PAGE) : 1;
    localparam int PCW = $clog2(MAX_PAGES + 1);
    localparam int BW  = $clog2(MAX_BLOCKS_PER_PAGE + 1);
    localparam int LINK_DEPTH = MAX_PAGES * MAX_BLOCKS_PER_PAGE;
    localparam int MEM_DEPTH  = MAX_PAGES * (2 ** IW);
    localparam int RECIP      = (2 ** HANDLE_W) / MAX_BLOCKS_PER_PAGE;

    // A list link: page slot and index of the next block, or the null mark.
    typedef struct packed {
        logic          nul;
        logic [PW-1:0] slot;
        logic [IW-1:0] idx;
    } t_link;

    localparam t_link LINK_NULL = '{nul: 1'b1, slot: '0, idx: '0};

    // Configuration registers and derived geometry.
    logic [REQ_W-1:0]    r_req;
    logic [ALIGN_W-1:0]  r_align;
    logic [PAGE_W-1:0]   r_page;
    logic [STRIDE_W-1:0] r_stride;
    logic [BW-1:0]       r_bip;

    // Pool state.
    t_state              r_state, n_state;
    t_link               r_head;
    logic [COUNT_W-1:0]  r_free;
    logic [PCW-1:0]      r_pages;
    logic [BW-1:0]       r_li;

    // Request capture and partial products.
    logic [HANDLE_W-1:0] r_fh;
    logic [FPROD_W-1:0]  r_fprod;
    logic [OFFSET_W-1:0] r_p1;
    logic [OFFSET_W-1:0] r_p2;

    // Pending result and output register.
    logic                r_res_pend;
    logic                r_res_status;
    logic [HANDLE_W-1:0] r_res_handle;
    logic [OFFSET_W-1:0] r_res_offset;
    logic [COUNT_W-1:0]  r_res_free;
    logic [PCW-1:0]      r_res_pages;
    logic                r_ov;
    logic                r_o_status;
    logic [HANDLE_W-1:0] r_o_handle;
    logic [OFFSET_W-1:0] r_o_offset;
    logic [COUNT_W-1:0]  r_o_free;
    logic [PCOUNT_W-1:0] r_o_pages;

    // Link memory.
    t_link               r_link_mem [MEM_DEPTH];
    t_link               r_rdata;

    // Control.
    logic                w_cfg_we;
    logic [REG_IDX_W-1:0] w_cfg_idx;
    logic                w_acc;
    logic                w_can_load;
    logic                w_load;
    logic                w_ready;
    t_op                 w_op;
    logic                w_need_page;
    logic                w_page_ok;
    logic                w_last_link;
    logic                w_mem_we;
    logic                w_mem_re;
    logic [PW+IW-1:0]    w_waddr;
    logic [PW+IW-1:0]    w_raddr;
    t_link               w_wdata;
    logic                w_div_start;
    logic                w_div_done;
    logic [DIV_W-1:0]    w_div_quot;

    // Derivation datapath.
    logic [STRIDE_W-1:0] w_m;
    logic [STRIDE_W-1:0] w_a;
    logic [STRIDE_W-1:0] w_sum;
    logic [STRIDE_W-1:0] w_str;
    logic [STRIDE_W-1:0] w_stride;
    logic [PAGE_W-1:0]   w_room;

    // Handle split and product operands.
    logic [HANDLE_W-1:0] w_qest;
    logic [31:0]         w_qd;
    logic [COUNT_W-1:0]  w_rem_raw;
    logic [HANDLE_W-1:0] w_q;
    logic [COUNT_W-1:0]  w_rem;
    logic                w_fvalid;
    t_link               w_fnode;
    logic [PW-1:0]       w_mslot;
    logic [PW-1:0]       w_pslot;
    logic [HANDLE_W-1:0] w_head_flat;
    logic [HANDLE_W-1:0] w_page_flat;

    // Configuration port: always ready, writes decoded by word address.
    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[APB_AW-1:2];
    assign w_cfg_we  = psel && penable && pwrite;

    always_comb begin
        unique case (w_cfg_idx)
            REG_REQ:   prdata = APB_DW'(r_req);
            REG_ALIGN: prdata = APB_DW'(r_align);
            REG_PAGE:  prdata = APB_DW'(r_page);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req   <= REQ_RESET;
            r_align <= ALIGN_RESET;
            r_page  <= PAGE_RESET;
        end else if (w_cfg_we) begin
            unique case (w_cfg_idx)
                REG_REQ:   r_req   <= pwdata[REQ_W-1:0];
                REG_ALIGN: r_align <= pwdata[ALIGN_W-1:0];
                REG_PAGE:  r_page  <= pwdata[PAGE_W-1:0];
                default:   ;
            endcase
        end
    end

    // Block stride: larger of request and header, rounded up by the mask.
    assign w_m   = (r_req < REQ_W'(BLOCK_HEADER_BYTES)) ? STRIDE_W'(BLOCK_HEADER_BYTES)
                                                        : STRIDE_W'(r_req);
    assign w_a   = (r_align == '0) ? STRIDE_W'(1) : STRIDE_W'(r_align);
    assign w_sum = w_m + w_a - STRIDE_W'(1);
    assign w_str = w_sum & ~(w_a - STRIDE_W'(1));
    assign w_stride = (w_str == '0) ? STRIDE_W'(1) : w_str;
    assign w_room = (r_page > PAGE_W'(PAGE_HEADER_BYTES))
                  ? r_page - PAGE_W'(PAGE_HEADER_BYTES) : '0;

    fbpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_room),
        .i_divisor  (w_stride),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    // Request decode.
    assign w_op        = t_op'(i_req.op);
    assign w_can_load  = !r_ov || o_rsp.ready;
    assign w_need_page = (r_free == '0);
    assign w_page_ok   = (32'(r_pages) < 32'(MAX_PAGES)) && (r_bip != '0);
    assign w_acc       = i_req.valid && w_ready;
    assign w_last_link = (r_li == r_bip - BW'(1));
    assign w_pslot     = r_pages[PW-1:0];

    // Split a freed handle into page slot and index: reciprocal estimate,
    // then one correcting subtraction.
    assign w_qest    = r_fprod[FPROD_W-1:HANDLE_W];
    assign w_qd      = 32'(w_qest) * 32'(MAX_BLOCKS_PER_PAGE);
    assign w_rem_raw = COUNT_W'(32'(r_fh) - w_qd);
    always_comb begin
        if (w_rem_raw >= COUNT_W'(MAX_BLOCKS_PER_PAGE)) begin
            w_q   = w_qest + HANDLE_W'(1);
            w_rem = w_rem_raw - COUNT_W'(MAX_BLOCKS_PER_PAGE);
        end else begin
            w_q   = w_qest;
            w_rem = w_rem_raw;
        end
    end
    assign w_fvalid = (32'(r_fh) < 32'(LINK_DEPTH));
    assign w_fnode  = '{nul: 1'b0, slot: w_q[PW-1:0], idx: w_rem[IW-1:0]};

    // Flat handles of the list head and of a newly opened page.
    assign w_head_flat = HANDLE_W'(32'(r_head.slot) * 32'(MAX_BLOCKS_PER_PAGE)
                                   + 32'(r_head.idx));
    assign w_page_flat = HANDLE_W'(32'(w_pslot) * 32'(MAX_BLOCKS_PER_PAGE));
    assign w_mslot     = w_need_page ? w_pslot : r_head.slot;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    case (w_op)
                        OP_ALLOC: begin
                            if (w_need_page) begin
                                n_state = w_page_ok ? ST_LINK : ST_IDLE;
                            end else begin
                                n_state = r_head.nul ? ST_IDLE : ST_POP;
                            end
                        end
                        OP_FREE: n_state = ST_FREE;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_POP:    n_state = ST_IDLE;
            ST_FREE:   n_state = ST_IDLE;
            ST_LINK:   n_state = w_last_link ? ST_IDLE : ST_LINK;
            ST_DERIVE: n_state = ST_DIV;
            ST_DIV:    n_state = w_div_done ? ST_IDLE : ST_DIV;
            default:   n_state = ST_DERIVE;
        endcase
        if (w_cfg_we) begin
            n_state = ST_DERIVE;
        end
    end

    // State outputs: handshake, memory port and divider start.
    always_comb begin
        w_ready     = 1'b0;
        w_load      = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_waddr     = {r_head.slot, r_head.idx};
        w_raddr     = {r_head.slot, r_head.idx};
        w_wdata     = r_head;
        w_div_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_load  = r_res_pend && w_can_load;
                w_ready = !r_res_pend || w_can_load;
                w_mem_re = i_req.valid && w_ready && (w_op == OP_ALLOC)
                           && !w_need_page && !r_head.nul;
            end
            ST_FREE: begin
                w_mem_we = w_fvalid;
                w_waddr  = {w_fnode.slot, w_fnode.idx};
                w_wdata  = r_head;
            end
            ST_LINK: begin
                w_mem_we = 1'b1;
                w_waddr  = {w_pslot, r_li[IW-1:0]};
                w_wdata  = w_last_link ? r_head
                         : '{nul: 1'b0, slot: w_pslot, idx: r_li[IW-1:0] + IW'(1)};
            end
            ST_DERIVE: w_div_start = 1'b1;
            default: ;
        endcase
    end

    assign i_req.ready = w_ready;

    // Link memory: one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_link_mem[w_waddr] <= w_wdata;
        end
        if (w_mem_re) begin
            r_rdata <= r_link_mem[w_raddr];
        end
    end

    // Controller and pool state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_DERIVE;
            r_head     <= LINK_NULL;
            r_free     <= '0;
            r_pages    <= '0;
            r_li       <= '0;
            r_res_pend <= 1'b0;
            r_stride   <= '0;
            r_bip      <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_res_pend <= 1'b0;
            end
            if (w_cfg_we) begin
                // A configuration write empties every page.
                r_head     <= LINK_NULL;
                r_free     <= '0;
                r_pages    <= '0;
                r_res_pend <= 1'b0;
            end else begin
                unique case (r_state)
                    ST_IDLE: begin
                        if (w_acc) begin
                            r_li <= '0;
                            case (w_op)
                                OP_ALLOC: begin
                                    if ((w_need_page && !w_page_ok)
                                        || (!w_need_page && r_head.nul)) begin
                                        r_res_pend <= 1'b1;
                                    end
                                end
                                OP_FREE: ;
                                OP_RELEASE: begin
                                    r_head     <= LINK_NULL;
                                    r_free     <= '0;
                                    r_pages    <= '0;
                                    r_res_pend <= 1'b1;
                                end
                                default: r_res_pend <= 1'b1;
                            endcase
                        end
                    end
                    ST_POP: begin
                        r_head     <= r_rdata;
                        r_free     <= r_free - COUNT_W'(1);
                        r_res_pend <= 1'b1;
                    end
                    ST_FREE: begin
                        if (w_fvalid) begin
                            r_head <= w_fnode;
                            if (r_free != COUNT_MAX) begin
                                r_free <= r_free + COUNT_W'(1);
                            end
                        end
                        r_res_pend <= 1'b1;
                    end
                    ST_LINK: begin
                        r_li <= r_li + BW'(1);
                        if (w_last_link) begin
                            // The first block of the new page is handed out now.
                            if (r_bip > BW'(1)) begin
                                r_head <= '{nul: 1'b0, slot: w_pslot, idx: IW'(1)};
                            end
                            r_pages    <= r_pages + PCW'(1);
                            r_free     <= COUNT_W'(r_bip) - COUNT_W'(1);
                            r_res_pend <= 1'b1;
                        end
                    end
                    ST_DERIVE: r_stride <= w_stride;
                    ST_DIV: begin
                        if (w_div_done) begin
                            r_bip <= (32'(w_div_quot) > 32'(MAX_BLOCKS_PER_PAGE))
                                   ? BW'(MAX_BLOCKS_PER_PAGE) : BW'(w_div_quot);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Request capture, partial products and result payload.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_fh    <= i_req.handle;
            r_fprod <= FPROD_W'(32'(i_req.handle) * 32'(RECIP));
            r_p1    <= OFFSET_W'(32'(w_mslot) * 32'(r_page));
            r_p2    <= OFFSET_W'(32'(r_head.idx) * 32'(r_stride));
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    r_res_status <= STATUS_OK;
                    r_res_handle <= '0;
                    r_res_offset <= '0;
                    r_res_free   <= r_free;
                    r_res_pages  <= r_pages;
                    case (w_op)
                        OP_ALLOC: r_res_status <= STATUS_OOM;
                        OP_RELEASE: begin
                            r_res_free  <= '0;
                            r_res_pages <= '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_POP: begin
                r_res_status <= STATUS_OK;
                r_res_handle <= w_head_flat;
                r_res_offset <= r_p1 + r_p2 + OFFSET_W'(PAGE_HEADER_BYTES);
                r_res_free   <= r_free - COUNT_W'(1);
                r_res_pages  <= r_pages;
            end
            ST_FREE: begin
                r_res_status <= STATUS_OK;
                r_res_handle <= '0;
                r_res_offset <= '0;
                r_res_pages  <= r_pages;
                r_res_free   <= (w_fvalid && (r_free != COUNT_MAX))
                              ? r_free + COUNT_W'(1) : r_free;
            end
            ST_LINK: begin
                r_res_status <= STATUS_OK;
                r_res_handle <= w_page_flat;
                r_res_offset <= r_p1 + OFFSET_W'(PAGE_HEADER_BYTES);
                r_res_free   <= COUNT_W'(r_bip) - COUNT_W'(1);
                r_res_pages  <= r_pages + PCW'(1);
            end
            default: ;
        endcase
    end

    // Output register: filled from the pending result, emptied on transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_status <= r_res_status;
            r_o_handle <= r_res_handle;
            r_o_offset <= r_res_offset;
            r_o_free   <= r_res_free;
            r_o_pages  <= PCOUNT_W'(r_res_pages);
        end
    end

    assign o_rsp.valid        = r_ov;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.block_handle = r_o_handle;
    assign o_rsp.byte_offset  = r_o_offset;
    assign o_rsp.free_count   = r_o_free;
    assign o_rsp.page_count   = r_o_pages;

    // The link memory is never written and read in the same cycle.
    a_mem_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mem_we && w_mem_re))
        else $error("link memory written and read in the same cycle");

    // A result only waits for the output register while the controller idles.
    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_pend |-> (r_state == ST_IDLE))
        else $error("pending result outside the idle state");

    // Pages in use never exceed the number of page slots.
    a_pages_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pages) <= 32'(MAX_PAGES))
        else $error("page count beyond the slot count");

    // Page linking stays inside the page and only opens a free slot.
    a_link_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LINK) |-> ((r_li < r_bip) && (32'(r_pages) < 32'(MAX_PAGES))))
        else $error("page linking out of range");

    // A pop only happens with a non-null head and a non-zero free count.
    a_pop_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP) |-> (!r_head.nul && (r_free != '0)))
        else $error("pop without a free block at the head");

endmodule

// ===== src/fbpa_div.sv =====
// ----------------------------------------------------------------------------
// fbpa_div
// Restoring unsigned divider, one quotient bit per cycle, used to work out
// how many blocks fit in a page.
// ----------------------------------------------------------------------------
module fbpa_div import fbpa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_W-1:0]     r_dvs;
    logic [DIV_W:0]       w_trial;

    // Trial subtraction of the divisor from the shifted partial remainder.
    assign w_trial = {r_rem, r_quo[DIV_W-1]} - {1'b0, r_dvs};

    // Control: busy while the quotient bits are worked out, then a done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DIV_CNT_W'(DIV_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath: shift the dividend through, keeping the partial remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!w_trial[DIV_W]) begin
                r_rem <= w_trial[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[DIV_W-2:0], r_quo[DIV_W-1]};
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule
